// File: src/valve_flow_safety_timer_top_macros.svh
// Assertion macros for the valve flow safety timer.
`ifndef VALVE_FLOW_SAFETY_TIMER_TOP_MACROS_SVH
`define VALVE_FLOW_SAFETY_TIMER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define VFST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("valve timer check failed");
`define VFST_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("valve timer check failed");
`else
`define VFST_ASSERT(label, prop)
`define VFST_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: src/vfst_pkg.sv
package vfst_pkg;

    localparam int FLOW_W     = 16;
    localparam int SECS_W     = 23;
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 33;
    localparam int REQ_W      = 2;
    localparam int CAUSE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [REQ_W-1:0] REQ_LOOP  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OPEN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_AUTO  = 2'd3;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_IDLE     = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_MAX_OPEN = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_INVALID  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FLOW_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OPEN         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CLR_AUTO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_ALERT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_TRIGGER     = 3'd5;

    localparam logic [FLOW_W-1:0] FLOW_THRESHOLD_RST = 16'd256;

    typedef struct packed {
        logic [FLOW_W-1:0]  flow_threshold;
        logic [LIMIT_W-1:0] idle_limit_ms;
        logic [LIMIT_W-1:0] open_time_limit_ms;
        logic               timeout_clears_auto;
        logic               timeout_alert_enable;
        logic               flow_trigger_select;
    } cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TIME_W-1:0] now_ms;
        logic [FLOW_W-1:0] flow_rate;
        logic              auto_enable;
    } req_t;

    typedef struct packed {
        logic               valve_is_open;
        logic               auto_mode_on;
        logic [CAUSE_W-1:0] safety_close_cause;
        logic               alert_raised;
    } res_t;

    // seconds * 1000 = s*1024 - s*16 - s*8, exact in 33 bits
    function automatic logic [LIMIT_W-1:0] secs_to_ms(input logic [SECS_W-1:0] secs);
        logic [LIMIT_W-1:0] s;
        s = {{(LIMIT_W-SECS_W){1'b0}}, secs};
        return (s << 10) - (s << 4) - (s << 3);
    endfunction

endpackage

// File: src/valve_flow_safety_timer_top.sv
// A request accepted into the request register moves on to the result register once the output is free.
// Throughput: one request per cycle while out_ready is not stalling; a request register feeds the step logic,
// which updates valve state and loads the result register in the same edge.
// Reset (async, active low): valve closed, auto mode on, threshold 1.0 l/min,
// both timeouts off, alerts on, flow trigger selected, both stages empty.
`include "valve_flow_safety_timer_top_macros.svh"

module valve_flow_safety_timer_top
    import vfst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [FLOW_W-1:0]     flow_rate,
    input  logic                  auto_enable,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  valve_is_open,
    output logic                  auto_mode_on,
    output logic [CAUSE_W-1:0]    safety_close_cause,
    output logic                  alert_raised
);

    cfg_t cfg;
    req_t req_reg;
    res_t res_next;
    res_t res_reg;
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic fire;
    logic res_has_cause;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || fire;

    vfst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vfst_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cfg      (cfg),
        .req      (req_reg),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.req_type    <= req_type;
            req_reg.now_ms      <= now_ms;
            req_reg.flow_rate   <= flow_rate;
            req_reg.auto_enable <= auto_enable;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign valve_is_open      = res_reg.valve_is_open;
    assign auto_mode_on       = res_reg.auto_mode_on;
    assign safety_close_cause = res_reg.safety_close_cause;
    assign alert_raised       = res_reg.alert_raised;

    assign res_has_cause = res_reg.safety_close_cause != CAUSE_NONE;

    `VFST_ASSERT(a_close_on_timeout, (out_valid_reg && res_has_cause) |-> !res_reg.valve_is_open)
    `VFST_ASSERT(a_alert_needs_cause, (out_valid_reg && res_reg.alert_raised) |-> res_has_cause)
    `VFST_ASSERT(a_stall_holds_request, (in_valid_reg && !out_free) |=> in_valid_reg)
    `VFST_ASSERT(a_cause_code, !out_valid_reg || (res_reg.safety_close_cause != CAUSE_INVALID))

endmodule

// File: src/vfst_cfg.sv
module vfst_cfg
    import vfst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // timeouts are kept in milliseconds so the per-request path only compares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flow_threshold       <= FLOW_THRESHOLD_RST;
            cfg_reg.idle_limit_ms        <= '0;
            cfg_reg.open_time_limit_ms   <= '0;
            cfg_reg.timeout_clears_auto  <= 1'b0;
            cfg_reg.timeout_alert_enable <= 1'b1;
            cfg_reg.flow_trigger_select  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLOW_THRESHOLD:   cfg_reg.flow_threshold <= cfg_data[FLOW_W-1:0];
                REG_IDLE_TIMEOUT:     cfg_reg.idle_limit_ms <= secs_to_ms(cfg_data[SECS_W-1:0]);
                REG_MAX_OPEN:
                    cfg_reg.open_time_limit_ms <= secs_to_ms(cfg_data[SECS_W-1:0]);
                REG_TIMEOUT_CLR_AUTO: cfg_reg.timeout_clears_auto <= cfg_data[0];
                REG_TIMEOUT_ALERT:    cfg_reg.timeout_alert_enable <= cfg_data[0];
                REG_FLOW_TRIGGER:     cfg_reg.flow_trigger_select <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/vfst_step.sv
module vfst_step
    import vfst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  cfg_t cfg,
    input  req_t req,
    output res_t res_next
);

    logic              open_reg, open_next;
    logic              auto_reg, auto_next;
    logic [TIME_W-1:0] opened_time_reg, opened_time_next;
    logic [TIME_W-1:0] last_flow_time_reg, last_flow_time_next;
    logic [TIME_W-1:0] idle_elapsed;
    logic [TIME_W-1:0] open_elapsed;
    logic [CAUSE_W-1:0] cause;
    logic              alert;
    logic              flowing;

    always_comb
    begin
        open_next           = open_reg;
        auto_next           = auto_reg;
        opened_time_next    = opened_time_reg;
        last_flow_time_next = last_flow_time_reg;
        idle_elapsed        = '0;
        open_elapsed        = '0;
        cause               = CAUSE_NONE;
        alert               = 1'b0;
        flowing             = req.flow_rate > cfg.flow_threshold;

        case (req.req_type)
            REQ_OPEN:
            begin
                if (!open_reg)
                begin
                    opened_time_next    = req.now_ms;
                    last_flow_time_next = req.now_ms;
                end
                open_next = 1'b1;
            end
            REQ_CLOSE:
            begin
                open_next           = 1'b0;
                opened_time_next    = '0;
                last_flow_time_next = '0;
            end
            REQ_AUTO:
            begin
                auto_next = req.auto_enable;
            end
            default:
            begin
                if (auto_reg && cfg.flow_trigger_select)
                begin
                    if (flowing && !open_reg)
                    begin
                        open_next           = 1'b1;
                        opened_time_next    = req.now_ms;
                        last_flow_time_next = req.now_ms;
                    end
                    else if (!flowing && open_reg)
                    begin
                        open_next           = 1'b0;
                        opened_time_next    = '0;
                        last_flow_time_next = '0;
                    end
                end
                if (open_next)
                begin
                    if (flowing)
                    begin
                        last_flow_time_next = req.now_ms;
                    end
                    // wrapping subtraction, compared against the exact 33-bit limit
                    idle_elapsed = req.now_ms - last_flow_time_next;
                    open_elapsed = req.now_ms - opened_time_next;
                    if ((cfg.idle_limit_ms != '0) &&
                        ({1'b0, idle_elapsed} >= cfg.idle_limit_ms))
                    begin
                        cause = CAUSE_IDLE;
                    end
                    else if ((cfg.open_time_limit_ms != '0) &&
                             ({1'b0, open_elapsed} >= cfg.open_time_limit_ms))
                    begin
                        cause = CAUSE_MAX_OPEN;
                    end
                    if (cause != CAUSE_NONE)
                    begin
                        open_next           = 1'b0;
                        opened_time_next    = '0;
                        last_flow_time_next = '0;
                        if (cfg.timeout_clears_auto)
                        begin
                            auto_next = 1'b0;
                        end
                        alert = cfg.timeout_alert_enable;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg           <= 1'b0;
            auto_reg           <= 1'b1;
            opened_time_reg    <= '0;
            last_flow_time_reg <= '0;
        end
        else if (fire)
        begin
            open_reg           <= open_next;
            auto_reg           <= auto_next;
            opened_time_reg    <= opened_time_next;
            last_flow_time_reg <= last_flow_time_next;
        end
    end

    assign res_next.valve_is_open      = open_next;
    assign res_next.auto_mode_on       = auto_next;
    assign res_next.safety_close_cause = cause;
    assign res_next.alert_raised       = alert;

endmodule

// File: verif/valve_timer_checker.sv
`timescale 1ns / 1ps
module valve_timer_checker
    import vfst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [FLOW_W-1:0]     flow_rate,
    input  logic                  auto_enable,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  valve_is_open,
    input  logic                  auto_mode_on,
    input  logic [CAUSE_W-1:0]    safety_close_cause,
    input  logic                  alert_raised,
    output int                    fail_count,
    output int                    pending
);

    localparam longint unsigned MS_PER_SEC = 1000;

    // shadow copy of the control registers
    logic [FLOW_W-1:0] thr_q;
    logic [SECS_W-1:0] idle_secs;
    logic [SECS_W-1:0] open_time_secs;
    logic              clears_auto;
    logic              alert_en;
    logic              flow_trigger;

    // shadow valve state
    logic              valve_open_q;
    logic              auto_q;
    logic [TIME_W-1:0] opened_at;
    logic [TIME_W-1:0] last_flow_at;

    res_t expected_status[$];

    // elapsed time wraps at 32 bits; the limit is formed without wrap
    function automatic bit timer_due(input logic [TIME_W-1:0] stamp,
                                     input logic [TIME_W-1:0] since,
                                     input logic [SECS_W-1:0] secs);
        logic [TIME_W-1:0] elapsed;
        elapsed = stamp - since;
        return longint'(elapsed) >= longint'(secs) * MS_PER_SEC;
    endfunction

    function automatic void open_valve(input logic [TIME_W-1:0] stamp);
        if (!valve_open_q)
        begin
            opened_at    = stamp;
            last_flow_at = stamp;
        end
        valve_open_q = 1'b1;
    endfunction

    function automatic void shut_valve();
        valve_open_q = 1'b0;
        opened_at    = '0;
        last_flow_at = '0;
    endfunction

    function automatic res_t predict_valve(input req_t r);
        res_t s;
        logic flowing;
        s = '0;
        case (r.req_type)
            REQ_OPEN:  open_valve(r.now_ms);
            REQ_CLOSE: shut_valve();
            REQ_AUTO:  auto_q = r.auto_enable;
            default:
            begin
                // loop step: automatic control, then the safety timers
                flowing = r.flow_rate > thr_q;
                if (auto_q && flow_trigger)
                begin
                    if (flowing && !valve_open_q)
                        open_valve(r.now_ms);
                    else if (!flowing && valve_open_q)
                        shut_valve();
                end
                if (valve_open_q)
                begin
                    if (flowing)
                        last_flow_at = r.now_ms;
                    // idle wins when both are due
                    if (idle_secs != '0 && timer_due(r.now_ms, last_flow_at, idle_secs))
                        s.safety_close_cause = CAUSE_IDLE;
                    else if (open_time_secs != '0 &&
                             timer_due(r.now_ms, opened_at, open_time_secs))
                        s.safety_close_cause = CAUSE_MAX_OPEN;
                    if (s.safety_close_cause != CAUSE_NONE)
                    begin
                        shut_valve();
                        if (clears_auto)
                            auto_q = 1'b0;
                        s.alert_raised = alert_en;
                    end
                end
            end
        endcase
        s.valve_is_open = valve_open_q;
        s.auto_mode_on  = auto_q;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        req_t r;
        if (!rst_n)
        begin
            thr_q          = FLOW_THRESHOLD_RST;
            idle_secs      = '0;
            open_time_secs = '0;
            clears_auto    = 1'b0;
            alert_en       = 1'b1;
            flow_trigger   = 1'b1;
            valve_open_q   = 1'b0;
            auto_q         = 1'b1;
            opened_at      = '0;
            last_flow_at   = '0;
            expected_status.delete();
            pending        = 0;
            fail_count     = 0;
        end
        else
        begin
            // a result always comes from an earlier request, so results are checked before new requests
            if (out_valid && out_ready)
            begin
                got = {valve_is_open, auto_mode_on, safety_close_cause, alert_raised};
                if (expected_status.size() == 0)
                begin
                    $error("result accepted with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (got.valve_is_open !== want.valve_is_open)
                    begin
                        $error("valve_is_open: expected %0d, got %0d",
                               want.valve_is_open, got.valve_is_open);
                        fail_count++;
                    end
                    if (got.auto_mode_on !== want.auto_mode_on)
                    begin
                        $error("auto_mode_on: expected %0d, got %0d",
                               want.auto_mode_on, got.auto_mode_on);
                        fail_count++;
                    end
                    if (got.safety_close_cause !== want.safety_close_cause)
                    begin
                        $error("safety_close_cause: expected %0d, got %0d",
                               want.safety_close_cause, got.safety_close_cause);
                        fail_count++;
                    end
                    if (got.alert_raised !== want.alert_raised)
                    begin
                        $error("alert_raised: expected %0d, got %0d",
                               want.alert_raised, got.alert_raised);
                        fail_count++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FLOW_THRESHOLD:   thr_q          = cfg_data[FLOW_W-1:0];
                    REG_IDLE_TIMEOUT:     idle_secs      = cfg_data[SECS_W-1:0];
                    REG_MAX_OPEN:         open_time_secs = cfg_data[SECS_W-1:0];
                    REG_TIMEOUT_CLR_AUTO: clears_auto    = cfg_data[0];
                    REG_TIMEOUT_ALERT:    alert_en       = cfg_data[0];
                    REG_FLOW_TRIGGER:     flow_trigger   = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                r = {req_type, now_ms, flow_rate, auto_enable};
                expected_status.push_back(predict_valve(r));
            end
            pending = expected_status.size();
        end
    end

endmodule

// File: verif/tb_valve_flow_safety_timer_top.sv
`timescale 1ns / 1ps
module tb_valve_flow_safety_timer_top;
    import vfst_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned MAX_WAIT    = 14;
    localparam int          PHASES      = 6;
    localparam int          PHASE_ITEMS = 63;
    // one step of almost 2^32 ms lands right around the largest timeout
    localparam logic [TIME_W-1:0] FAR_STEP = 32'd4294966800;
    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type;
    logic [TIME_W-1:0]     now_ms;
    logic [FLOW_W-1:0]     flow_rate;
    logic                  auto_enable;
    logic                  out_valid;
    logic                  out_ready;
    logic                  valve_is_open;
    logic                  auto_mode_on;
    logic [CAUSE_W-1:0]    safety_close_cause;
    logic                  alert_raised;

    int                fail_count;
    int                pending;
    int unsigned       quiet_cycles = 0;
    logic [TIME_W-1:0] ms_now;
    logic [FLOW_W-1:0] cur_thr;
    bit                send_burst;
    bit                recv_burst;

    valve_flow_safety_timer_top DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .req_type           (req_type),
        .now_ms             (now_ms),
        .flow_rate          (flow_rate),
        .auto_enable        (auto_enable),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .valve_is_open      (valve_is_open),
        .auto_mode_on       (auto_mode_on),
        .safety_close_cause (safety_close_cause),
        .alert_raised       (alert_raised)
    );

    valve_timer_checker status_chk (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .req_type           (req_type),
        .now_ms             (now_ms),
        .flow_rate          (flow_rate),
        .auto_enable        (auto_enable),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .valve_is_open      (valve_is_open),
        .auto_mode_on       (auto_mode_on),
        .safety_close_cause (safety_close_cause),
        .alert_raised       (alert_raised),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // random waits, with occasional stretches of back-to-back traffic
    function automatic int unsigned pick_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [FLOW_W-1:0] pick_flow();
        case ($urandom_range(0, 3))
            0: return FLOW_W'($urandom);
            1: return cur_thr;
            2: return (cur_thr == '1) ? cur_thr :
                      FLOW_W'($urandom_range(int'(cur_thr) + 1, 65535));
            default: return FLOW_W'($urandom_range(0, int'(cur_thr)));
        endcase
    endfunction

    task automatic push_request(input logic [REQ_W-1:0]  kind,
                                input logic [TIME_W-1:0] stamp,
                                input logic [FLOW_W-1:0] flow,
                                input logic              en);
        int unsigned gap;
        gap = pick_wait(send_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        now_ms      <= stamp;
        flow_rate   <= flow;
        auto_enable <= en;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] thr,
                                 input logic [CFG_DATA_W-1:0] idle,
                                 input logic [CFG_DATA_W-1:0] open_time,
                                 input logic [CFG_DATA_W-1:0] clr_auto,
                                 input logic [CFG_DATA_W-1:0] alert,
                                 input logic [CFG_DATA_W-1:0] trigger);
        write_reg(REG_FLOW_THRESHOLD, thr);
        write_reg(REG_IDLE_TIMEOUT, idle);
        write_reg(REG_MAX_OPEN, open_time);
        write_reg(REG_TIMEOUT_CLR_AUTO, clr_auto);
        write_reg(REG_TIMEOUT_ALERT, alert);
        write_reg(REG_FLOW_TRIGGER, trigger);
        cur_thr = thr[FLOW_W-1:0];
    endtask

    // drop valid and let every outstanding request drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic random_request(input bit far);
        int unsigned       pick;
        logic [REQ_W-1:0]  kind;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            kind = REQ_LOOP;
        else if (pick < 73)
            kind = REQ_OPEN;
        else if (pick < 80)
            kind = REQ_CLOSE;
        else
            kind = REQ_AUTO;
        // mostly a forward-running clock, now and then a jump anywhere
        if ($urandom_range(0, 19) == 0)
            ms_now = $urandom;
        else if (far && $urandom_range(0, 1) == 1)
            ms_now = ms_now + FAR_STEP + $urandom_range(0, 400);
        else
            ms_now = ms_now + $urandom_range(0, 1200);
        push_request(kind, ms_now, pick_flow(), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            int unsigned stall;
            stall = pick_wait(recv_burst);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = REQ_LOOP;
        now_ms       = '0;
        flow_rate    = '0;
        auto_enable  = 1'b0;
        cur_thr      = FLOW_THRESHOLD_RST;
        ms_now       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: auto control only, no timers
        push_request(REQ_LOOP, 32'd0, 16'd0, 1'b0);
        push_request(REQ_LOOP, 32'd100, 16'hFFFF, 1'b1);
        push_request(REQ_OPEN, 32'd200, 16'd0, 1'b0);          // already open
        push_request(REQ_LOOP, 32'd300, 16'd256, 1'b0);        // equal to threshold closes
        push_request(REQ_LOOP, 32'd400, 16'd257, 1'b0);
        push_request(REQ_CLOSE, 32'd500, 16'hFFFF, 1'b1);
        push_request(REQ_AUTO, 32'd600, 16'd0, 1'b0);
        push_request(REQ_LOOP, 32'd700, 16'hFFFF, 1'b1);
        push_request(REQ_OPEN, 32'd800, 16'd0, 1'b0);
        push_request(REQ_LOOP, 32'hFFFF_FFFF, 16'd0, 1'b0);
        push_request(REQ_AUTO, 32'd900, 16'd0, 1'b1);

        settle();
        apply_setting(23'd256, 23'd1, 23'd2, 23'd1, 23'd1, 23'd1);
        push_request(REQ_AUTO, 32'd950, 16'd0, 1'b0);
        push_request(REQ_OPEN, 32'd1000, 16'd0, 1'b0);
        push_request(REQ_LOOP, 32'd1999, 16'd0, 1'b0);         // one ms short
        push_request(REQ_LOOP, 32'd2000, 16'd0, 1'b0);         // idle on the boundary
        push_request(REQ_OPEN, 32'd5000, 16'd0, 1'b0);
        push_request(REQ_LOOP, 32'd6000, 16'hFFFF, 1'b0);
        push_request(REQ_LOOP, 32'd7000, 16'hFFFF, 1'b0);      // max open
        push_request(REQ_OPEN, 32'hFFFF_F000, 16'd0, 1'b0);
        push_request(REQ_LOOP, 32'h0000_0800, 16'd0, 1'b0);    // wrap, both due
        push_request(REQ_AUTO, 32'h0000_0900, 16'd0, 1'b1);
        push_request(REQ_LOOP, 32'h0000_0A00, 16'hFFFF, 1'b0);
        push_request(REQ_LOOP, 32'h0000_0B00, 16'd0, 1'b1);

        ms_now = 32'h0000_1000;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: apply_setting(23'd0, 23'd1, 23'd3, 23'd0, 23'd1, 23'd1);
                1: apply_setting(23'hFFFF, 23'd2, 23'd0, 23'd1, 23'd0, 23'd0);
                2: apply_setting(CFG_DATA_W'($urandom), 23'd4294967, 23'd4294967,
                                 CFG_DATA_W'($urandom_range(0, 1)),
                                 CFG_DATA_W'($urandom_range(0, 1)), 23'd1);
                3:
                begin
                    // limits whose product overflows 32 bits never expire
                    apply_setting(CFG_DATA_W'($urandom), 23'h7FFFFF, 23'h7FFFFF,
                                  23'd1, 23'd1, CFG_DATA_W'($urandom_range(0, 1)));
                    write_reg(REG_SPARE_A, '1);
                    write_reg(REG_SPARE_B, '0);
                end
                default: apply_setting(CFG_DATA_W'($urandom),
                                       CFG_DATA_W'($urandom_range(0, 4)),
                                       CFG_DATA_W'($urandom_range(0, 6)),
                                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                       CFG_DATA_W'($urandom));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request(phase == 2);
        end

        settle();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/vfst_pkg.sv
src/vfst_cfg.sv
src/vfst_step.sv
src/valve_flow_safety_timer_top.sv
verif/valve_timer_checker.sv
verif/tb_valve_flow_safety_timer_top.sv
